// ===== src/anrh_pkg.sv =====
`default_nettype none

package anrh_pkg;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 32;
   localparam int IDX_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;
   localparam int MARK_W   = ID_W + 1;

   typedef enum logic [KIND_W-1:0] {
      OP_ADD_ACK = 2'd0,
      OP_ADD_NAK = 2'd1,
      OP_RELEASE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_BEYOND    = 3'd2,
      STS_BELOW     = 3'd3,
      STS_FULL      = 3'd4,
      STS_BAD_INDEX = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_LAST,
      ST_ADD_PREV,
      ST_REL_LAST,
      ST_REL_SCAN,
      ST_REL_NEXT,
      ST_SHIFT,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic            nak;
      logic [ID_W-1:0] id;
   } mark_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
      logic               entry_is_nak;
      logic [ID_W-1:0]    entry_payload_id;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } seq_out_type;

endpackage

`default_nettype wire

// ===== src/anrh_req_if.sv =====
`default_nettype none

interface anrh_req_if;
   import anrh_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   payload_id;
   logic [IDX_W-1:0]  read_index;

   modport source (output valid, output kind, output payload_id, output read_index,
                   input ready);
   modport sink (input valid, input kind, input payload_id, input read_index,
                 output ready);
endinterface

`default_nettype wire

// ===== src/anrh_rsp_if.sv =====
`default_nettype none

interface anrh_rsp_if;
   import anrh_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;
   logic                entry_is_nak;
   logic [ID_W-1:0]     entry_payload_id;

   modport source (output valid, output status, output entry_count, output entry_is_nak,
                   output entry_payload_id, input ready);
   modport sink (input valid, input status, input entry_count, input entry_is_nak,
                 input entry_payload_id, output ready);
endinterface

`default_nettype wire

// ===== src/anrh_ram.sv =====
`default_nettype none

module anrh_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/anrh_seq.sv =====
`default_nettype none

module anrh_seq #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   anrh_req_if.sink                   req_chan,
   input  logic                       out_free,
   output anrh_pkg::seq_out_type      seq_out,
   output logic                       ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
   output anrh_pkg::mark_type         ram_wr_data,
   output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
   input  anrh_pkg::mark_type         ram_rd_data
);
   import anrh_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   ptr_ff, ptr_in;     // scan position, then shift source
   logic [CW-1:0]   dst_ff, dst_in;
   logic            pend_ff, pend_in;   // read data waiting to be written in shift
   logic            last_nak_ff, last_nak_in;
   logic            prev_nak_ff, prev_nak_in;
   status_type      status_ff, status_in;
   logic            rd_nak_ff, rd_nak_in;
   logic [ID_W-1:0] rd_id_ff, rd_id_in;

   logic            accept;
   op_type          req_op;
   logic [CW-1:0]   cnt_m1, cnt_m2, ptr_p1;
   logic [ID_W-1:0] id_next;
   logic            found, equal, beyond, idx_ok, src_left;
   logic            prev_ack, append, skip;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_op   = op_type'(req_chan.kind);
   assign cnt_m1   = cnt_ff - CW'(1);
   assign cnt_m2   = cnt_ff - CW'(2);
   assign ptr_p1   = ptr_ff + CW'(1);
   assign id_next  = id_ff + ID_W'(1);
   assign found    = ram_rd_data.id >= id_ff;
   assign equal    = ram_rd_data.id == id_ff;
   assign beyond   = id_ff > ram_rd_data.id;
   assign idx_ok   = XW'(req_chan.read_index) < XW'(cnt_ff);
   assign src_left = ptr_ff < cnt_ff;

   // compression rules for an add, decided once the two trailing marks are read
   always_comb begin
      prev_ack = (cnt_ff > CW'(1)) && !ram_rd_data.nak;
      skip     = 1'b0;
      if (cnt_ff == '0) begin
         append = 1'b1;
      end else if (op_ff == OP_ADD_ACK) begin
         append = last_nak_ff || !prev_ack;
      end else begin
         skip   = last_nak_ff;
         append = !prev_ack;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ADD_ACK, OP_ADD_NAK: state_in = ST_ADD_LAST;
                  OP_RELEASE:             state_in = (cnt_ff == '0) ? ST_RESP : ST_REL_LAST;
                  OP_READ:                state_in = idx_ok ? ST_READ : ST_RESP;
               endcase
            end
         end
         ST_ADD_LAST: state_in = ST_ADD_PREV;
         ST_ADD_PREV: state_in = ST_RESP;
         ST_REL_LAST: state_in = beyond ? ST_RESP : ST_REL_SCAN;
         ST_REL_SCAN: begin
            if (found) begin
               if (equal) begin
                  state_in = (ptr_p1 < cnt_ff) ? ST_REL_NEXT : ST_RESP;
               end else begin
                  state_in = (ptr_ff == '0) ? ST_RESP : ST_SHIFT;
               end
            end
         end
         ST_REL_NEXT: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (!pend_ff && !src_left) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      dst_in      = dst_ff;
      pend_in     = pend_ff;
      last_nak_in = last_nak_ff;
      prev_nak_in = prev_nak_ff;
      status_in   = status_ff;
      rd_nak_in   = rd_nak_ff;
      rd_id_in    = rd_id_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_addr = '0;
      seq_out     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               id_in     = req_chan.payload_id;
               status_in = STS_OK;
               rd_nak_in = 1'b0;
               rd_id_in  = '0;
               unique case (req_op)
                  OP_ADD_ACK, OP_ADD_NAK: ram_rd_addr = cnt_m1[AW-1:0];
                  OP_RELEASE: begin
                     if (cnt_ff == '0) begin
                        status_in = STS_EMPTY;
                     end else begin
                        ram_rd_addr = cnt_m1[AW-1:0];
                     end
                  end
                  OP_READ: begin
                     if (idx_ok) begin
                        ram_rd_addr = AW'(req_chan.read_index);
                     end else begin
                        status_in = STS_BAD_INDEX;
                     end
                  end
               endcase
            end
         end
         ST_ADD_LAST: begin
            last_nak_in = ram_rd_data.nak;
            ram_rd_addr = cnt_m2[AW-1:0];
         end
         ST_ADD_PREV: begin
            ram_wr_data.nak = (op_ff == OP_ADD_NAK);
            ram_wr_data.id  = id_ff;
            if (!skip) begin
               if (append) begin
                  if (cnt_ff == CW'(DEPTH)) begin
                     status_in = STS_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cnt_ff[AW-1:0];
                     cnt_in      = cnt_ff + CW'(1);
                  end
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cnt_m1[AW-1:0];
               end
            end
         end
         ST_REL_LAST: begin
            if (beyond) begin
               status_in = STS_BEYOND;
            end else begin
               ptr_in = '0;
            end
         end
         ST_REL_SCAN: begin
            if (found) begin
               if (equal) begin
                  if (ptr_p1 < cnt_ff) begin
                     ram_rd_addr = ptr_p1[AW-1:0];
                     last_nak_in = ram_rd_data.nak;
                  end else begin
                     cnt_in = '0;
                  end
               end else if (ptr_ff == '0) begin
                  status_in = STS_BELOW;
               end else begin
                  // front becomes the kind below with the released id
                  ram_wr_en       = 1'b1;
                  ram_wr_data.nak = prev_nak_ff;
                  ram_wr_data.id  = id_ff;
                  dst_in          = CW'(1);
                  pend_in         = 1'b0;
               end
            end else begin
               prev_nak_in = ram_rd_data.nak;
               ptr_in      = ptr_p1;
               ram_rd_addr = ptr_p1[AW-1:0];
            end
         end
         ST_REL_NEXT: begin
            ptr_in  = ptr_p1;
            pend_in = 1'b0;
            if (ram_rd_data.id == id_next) begin
               dst_in = '0;
            end else begin
               ram_wr_en       = 1'b1;
               ram_wr_data.nak = last_nak_ff;
               ram_wr_data.id  = id_next;
               dst_in          = CW'(1);
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff[AW-1:0];
               ram_wr_data = ram_rd_data;
               dst_in      = dst_ff + CW'(1);
            end
            if (src_left) begin
               ram_rd_addr = ptr_ff[AW-1:0];
               ptr_in      = ptr_p1;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cnt_in = dst_ff;
               end
            end
         end
         ST_READ: begin
            rd_nak_in = ram_rd_data.nak;
            rd_id_in  = ram_rd_data.id;
         end
         ST_RESP: begin
            seq_out.push                  = out_free;
            seq_out.data.status           = status_ff;
            seq_out.data.entry_count      = COUNT_W'(cnt_ff);
            seq_out.data.entry_is_nak     = rd_nak_ff;
            seq_out.data.entry_payload_id = rd_id_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      op_ff       <= op_in;
      id_ff       <= id_in;
      ptr_ff      <= ptr_in;
      dst_ff      <= dst_in;
      last_nak_ff <= last_nak_in;
      prev_nak_ff <= prev_nak_in;
      status_ff   <= status_in;
      rd_nak_ff   <= rd_nak_in;
      rd_id_ff    <= rd_id_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> dst_ff <= ptr_ff)
      else $error("shift destination passed its source");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

// ===== src/ack_nak_range_history.sv =====
// Add: the last two marks are read, then the new mark is appended, merged or dropped.
// Read: one RAM read, skipped for a bad index. Release: one RAM read per cycle for the
// scan, then one entry moved per cycle; the single-port read of the mark RAM sets this
// pace. One request is in work at a time.
// Synchronous reset empties the table; RAM contents are not cleared.
`default_nettype none

module ack_nak_range_history #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   anrh_req_if.sink    req_chan,
   anrh_rsp_if.source  rsp_chan
);
   import anrh_pkg::*;

   localparam int AW = $clog2(DEPTH);

   seq_out_type     seq_out;
   logic            out_free;
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic [AW-1:0]   ram_rd_addr;
   mark_type        ram_wr_data;
   mark_type        ram_rd_data;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   anrh_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .out_free    (out_free),
      .seq_out     (seq_out),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   anrh_ram #(
      .WIDTH(MARK_W),
      .DEPTH(DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_out.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_out.data;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_data_ff.status;
   assign rsp_chan.entry_count      = rsp_data_ff.entry_count;
   assign rsp_chan.entry_is_nak     = rsp_data_ff.entry_is_nak;
   assign rsp_chan.entry_payload_id = rsp_data_ff.entry_payload_id;

endmodule

`default_nettype wire
